// ===== rtl/slcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package slcs_pkg;

  typedef enum logic [2:0] {
    ST_BOOT      = 3'd0,
    ST_WAIT_HOST = 3'd1,
    ST_HOST_UP   = 3'd2,
    ST_WAIT_CTRL = 3'd3,
    ST_READY     = 3'd4,
    ST_ACTIVE    = 3'd5,
    ST_ERROR     = 3'd6
  } mode_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // lamp kind register codes, kind 3 behaves as no lamp
  localparam logic [1:0] LAMP_NONE   = 2'd0;
  localparam logic [1:0] LAMP_SINGLE = 2'd1;
  localparam logic [1:0] LAMP_COLOR  = 2'd2;

  // register indexes on the config port
  localparam logic [1:0] REG_LAMP_KIND  = 2'd0;
  localparam logic [1:0] REG_SLOW_BLINK = 2'd1;
  localparam logic [1:0] REG_FAST_BLINK = 2'd2;

  localparam logic [15:0] SLOW_BLINK_RESET = 16'd1000;
  localparam logic [15:0] FAST_BLINK_RESET = 16'd200;

  localparam logic [7:0]  ACTIVITY_HOLD_MS = 8'd250;
  localparam logic [10:0] BOOT_HOLD_MS     = 11'd1800;

  // heartbeat window per state, in ms
  function automatic logic [8:0] window_of(mode_t s);
    logic [8:0] w;
    unique case (s)
      ST_ERROR:     w = 9'd120;
      ST_BOOT:      w = 9'd180;
      ST_WAIT_HOST: w = 9'd260;
      ST_WAIT_CTRL: w = 9'd350;
      ST_ACTIVE:    w = 9'd80;
      ST_READY:     w = 9'd500;
      default:      w = 9'd300;
    endcase
    return w;
  endfunction

  function automatic rgb_t colour_of(mode_t s, logic p);
    rgb_t c;
    c = '0;
    unique case (s)
      ST_BOOT: begin
        c.red   = p ? 8'd64 : 8'd0;
        c.green = p ? 8'd0  : 8'd16;
        c.blue  = 8'd64;
      end
      ST_WAIT_HOST: c.blue = p ? 8'd64 : 8'd16;
      ST_HOST_UP: begin
        c.green = p ? 8'd64 : 8'd24;
        c.blue  = p ? 8'd32 : 8'd16;
      end
      ST_WAIT_CTRL: begin
        c.red   = p ? 8'd64 : 8'd16;
        c.green = p ? 8'd24 : 8'd8;
      end
      ST_READY: c.green = p ? 8'd96 : 8'd32;
      ST_ACTIVE: begin
        c.green = p ? 8'd96 : 8'd16;
        c.blue  = p ? 8'd64 : 8'd16;
      end
      ST_ERROR: c.red = p ? 8'd120 : 8'd16;
      default:  c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/status_lamp_color_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   signals                                   direction
// --------  ----------------------------------------  ---------
// in        in_valid/in_ready, operation, now_ms,      input
//           host_linked, controller_present,
//           simulated, startup_expired
// out       out_valid/out_ready, red, green, blue,     output
//           lamp_on
// cfg       cfg_we, cfg_index, cfg_data                input, write only
//
// one item per cycle while the skid is free: an input transfer lands in the
// input register, then the state rule and heartbeat update all state at once
// results go to a two-entry output queue (output register plus skid), so the
// input side keeps taking items while one result waits to be taken
// a stalled output only holds the input register once the skid entry is full
// rst is synchronous, active high; it resets config, state and valid flags

module status_lamp_color_sequencer
  import slcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [31:0] now_ms,
  input  wire logic        host_linked,
  input  wire logic        controller_present,
  input  wire logic        simulated,
  input  wire logic        startup_expired,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic             lamp_on,
  // config write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // config registers
  logic [1:0]  lamp_kind;
  logic [15:0] slow_blink_ms;
  logic [15:0] fast_blink_ms;

  // input register
  logic        s1_valid;
  logic        s1_op;
  logic [31:0] s1_now;
  logic        s1_host;
  logic        s1_driven;
  logic        s1_expired;

  // block state
  mode_t       mode_state, mode_next;
  logic [31:0] state_start_time;
  logic [31:0] activity_time;
  logic [31:0] beat_time;
  logic        beat_phase;
  rgb_t        shown;

  // output queue
  logic        skid_valid;
  rgb_t        out_rgb, skid_rgb;
  logic        skid_lamp;

  // per-item results
  logic        s1_advance;
  logic        push;
  rgb_t        res_rgb;
  logic        res_lamp;
  logic        beat_toggle;
  logic        pop;

  logic [31:0] act_elapsed;
  logic [31:0] start_elapsed;
  logic [31:0] beat_elapsed;
  logic [15:0] period;
  rgb_t        colour;
  logic        phase_next;

  // input register only waits when the skid entry is occupied
  assign s1_advance = s1_valid && !skid_valid;
  assign in_ready   = !s1_valid || !skid_valid;
  assign pop        = out_valid && out_ready;

  assign red   = out_rgb.red;
  assign green = out_rgb.green;
  assign blue  = out_rgb.blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      lamp_kind     <= LAMP_COLOR;
      slow_blink_ms <= SLOW_BLINK_RESET;
      fast_blink_ms <= FAST_BLINK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LAMP_KIND:  lamp_kind     <= cfg_data[1:0];
        REG_SLOW_BLINK: slow_blink_ms <= cfg_data;
        REG_FAST_BLINK: fast_blink_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op      <= operation;
      s1_now     <= now_ms;
      s1_host    <= host_linked;
      s1_driven  <= controller_present || simulated;
      s1_expired <= startup_expired;
    end
  end

  // elapsed times wrap modulo 2^32
  assign act_elapsed   = s1_now - activity_time;
  assign start_elapsed = s1_now - state_start_time;
  assign beat_elapsed  = s1_now - beat_time;

  // state rule
  always_comb begin
    mode_next = mode_state;
    if (s1_op) begin
      mode_next = ST_ACTIVE;
    end else if (s1_expired) begin
      mode_next = ST_ERROR;
    end else if (mode_state == ST_ACTIVE) begin
      if (act_elapsed > 32'(ACTIVITY_HOLD_MS)) begin
        if (s1_host && s1_driven) mode_next = ST_READY;
        else if (s1_host)         mode_next = ST_HOST_UP;
        else                      mode_next = ST_WAIT_HOST;
      end
    end else begin
      if (!s1_host && start_elapsed < 32'(BOOT_HOLD_MS)) mode_next = ST_BOOT;
      else if (!s1_host)                                 mode_next = ST_WAIT_HOST;
      else if (!s1_driven)                               mode_next = ST_WAIT_CTRL;
      else                                               mode_next = ST_READY;
    end
  end

  // heartbeat and result
  always_comb begin
    period      = s1_driven ? slow_blink_ms : fast_blink_ms;
    beat_toggle = 1'b0;
    push        = 1'b0;
    res_rgb     = '0;
    if (s1_advance && !s1_op) begin
      if (lamp_kind == LAMP_SINGLE) begin
        beat_toggle = beat_elapsed >= 32'(period);
        push        = beat_toggle;
      end else if (lamp_kind == LAMP_COLOR) begin
        beat_toggle = beat_elapsed >= 32'(window_of(mode_next));
      end
    end
    phase_next = beat_phase ^ beat_toggle;
    colour     = colour_of(mode_next, phase_next);
    if (s1_advance && !s1_op && lamp_kind == LAMP_COLOR) begin
      res_rgb = colour;
      push    = colour != shown;
    end
    res_lamp = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_state       <= ST_BOOT;
      state_start_time <= '0;
      activity_time    <= '0;
      beat_time        <= '0;
      beat_phase       <= 1'b0;
      shown            <= '0;
    end else if (s1_advance) begin
      mode_state <= mode_next;
      if (s1_op) begin
        // activity mark restarts the state and activity timers
        state_start_time <= s1_now;
        activity_time    <= s1_now;
      end
      if (beat_toggle) begin
        beat_time  <= s1_now;
        beat_phase <= phase_next;
      end
      if (!s1_op && lamp_kind == LAMP_COLOR) begin
        shown <= colour;
      end
    end
  end

  // output register plus skid entry, in transfer order
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid) out_valid <= 1'b1;
      else            skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      out_rgb <= skid_rgb;
      lamp_on <= skid_lamp;
    end else if (push && (!out_valid || pop)) begin
      out_rgb <= res_rgb;
      lamp_on <= res_lamp;
    end
    if (push && out_valid && !pop) begin
      skid_rgb  <= res_rgb;
      skid_lamp <= res_lamp;
    end
  end

  // skid entry only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a result with the output register empty");

  // a result never arrives while both queue entries are taken
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("result pushed into a full output queue");

  a_activity_enters: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_op) |=> (mode_state == ST_ACTIVE))
    else $error("activity mark did not enter the activity state");

  a_expired_error: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && !s1_op && s1_expired) |=> (mode_state == ST_ERROR))
    else $error("start-up timeout did not force the error state");

  a_no_lamp_silent: assert property (@(posedge clk) disable iff (rst)
    (lamp_kind != LAMP_SINGLE && lamp_kind != LAMP_COLOR) |-> !push)
    else $error("result produced with no lamp fitted");

endmodule

`default_nettype wire

// ===== tb/status_lamp_color_sequencer_tb.sv =====
`timescale 1ns / 1ps

module status_lamp_color_sequencer_tb;
  import slcs_pkg::*;

  // item operations
  localparam logic OP_UPDATE   = 1'b0;
  localparam logic OP_ACTIVITY = 1'b1;

  // kind 3 is not a real lamp and must act as no lamp
  localparam logic [1:0] LAMP_SPARE = 2'd3;

  // timing rules of the state machine, in ms
  localparam logic [31:0] ACTIVE_LINGER_MS = 32'd250;
  localparam logic [31:0] BOOT_GRACE_MS    = 32'd1800;

  localparam int unsigned SETTLE_CYCLES = 8;       // input reg, update, two-entry queue
  localparam int unsigned LONG_HOLD     = 300;     // receiver hold-off, in cycles
  localparam int unsigned CYCLE_LIMIT   = 400000;

  typedef enum logic [1:0] {
    PACE_FULL,        // no idling on either side
    PACE_SEND_GAPS,   // sender idles with chance 47 in 100 per try
    PACE_RECV_STALLS, // receiver stalls with chance 47 in 100
    PACE_BOTH         // both, each with chance 26 in 100
  } pace_t;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,   // result comes from the local model
    CHK_SILENT,  // the row must produce no result
    CHK_RESULT   // the row carries its own result
  } check_t;

  typedef struct packed {
    logic        op;
    logic [31:0] stamp;
    logic        host;
    logic        ctrl;
    logic        sim;
    logic        expired;
  } lamp_item_t;

  typedef struct packed {
    rgb_t color;
    logic lamp;
  } lamp_result_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] slow;
    logic [15:0] fast;
    logic        op;
    logic [31:0] stamp;
    logic [3:0]  flags;   // host, controller, simulated, start-up expired
    check_t      check;
    logic [23:0] colour;
    logic        lamp;
  } directed_row_t;

  localparam int unsigned DIRECTED_ROWS = 25;

  // the first rows start from reset, so their results can be read off directly
  directed_row_t directed_table [0:DIRECTED_ROWS-1] = '{
    // boot color, a silent repeat, then boot with the phase flipped, then the error color
    '{LAMP_COLOR, 16'd1000, 16'd200, OP_UPDATE, 32'd0, 4'b0000, CHK_RESULT, 24'h001040, 1'b0},
    '{LAMP_COLOR, 16'd1000, 16'd200, OP_UPDATE, 32'd0, 4'b0000, CHK_SILENT, 24'h0, 1'b0},
    '{LAMP_COLOR, 16'd1000, 16'd200, OP_UPDATE, 32'd180, 4'b0000, CHK_RESULT, 24'h400040, 1'b1},
    '{LAMP_COLOR, 16'd1000, 16'd200, OP_UPDATE, 32'd180, 4'b0001, CHK_RESULT, 24'h780000, 1'b1},
    // activity mark and the way out of the activity state
    '{LAMP_COLOR, 16'd1000, 16'd200, OP_ACTIVITY, 32'd300, 4'b1111, CHK_SILENT, 24'h0, 1'b0},
    '{LAMP_COLOR, 16'd1000, 16'd200, OP_UPDATE, 32'd380, 4'b1100, CHK_MODEL, 24'h0, 1'b0},
    '{LAMP_COLOR, 16'd1000, 16'd200, OP_UPDATE, 32'd551, 4'b1010, CHK_MODEL, 24'h0, 1'b0},
    // top of the time range and wrap through zero
    '{LAMP_COLOR, 16'd1000, 16'd200, OP_UPDATE, 32'hFFFFFFFF, 4'b0000, CHK_MODEL, 24'h0, 1'b0},
    '{LAMP_COLOR, 16'd1000, 16'd200, OP_UPDATE, 32'd99, 4'b1000, CHK_MODEL, 24'h0, 1'b0},
    '{LAMP_COLOR, 16'd1000, 16'd200, OP_UPDATE, 32'd512, 4'b1000, CHK_MODEL, 24'h0, 1'b0},
    '{LAMP_COLOR, 16'd1000, 16'd200, OP_ACTIVITY, 32'hFFFFFF00, 4'b0000, CHK_SILENT, 24'h0, 1'b0},
    '{LAMP_COLOR, 16'd1000, 16'd200, OP_UPDATE, 32'd16, 4'b1000, CHK_MODEL, 24'h0, 1'b0},
    '{LAMP_COLOR, 16'd1000, 16'd200, OP_UPDATE, 32'd16, 4'b1001, CHK_MODEL, 24'h0, 1'b0},
    // single lamp, slow and fast period
    '{LAMP_SINGLE, 16'd1000, 16'd200, OP_UPDATE, 32'd256, 4'b0100, CHK_MODEL, 24'h0, 1'b0},
    '{LAMP_SINGLE, 16'd1000, 16'd200, OP_UPDATE, 32'd256, 4'b0000, CHK_MODEL, 24'h0, 1'b0},
    // zero period toggles on every update
    '{LAMP_SINGLE, 16'd0, 16'd0, OP_UPDATE, 32'd256, 4'b0010, CHK_MODEL, 24'h0, 1'b0},
    '{LAMP_SINGLE, 16'd0, 16'd0, OP_UPDATE, 32'd256, 4'b0000, CHK_MODEL, 24'h0, 1'b0},
    // largest period, one ms short and then exactly on it
    '{LAMP_SINGLE, 16'd65535, 16'd65535, OP_UPDATE, 32'd65790, 4'b1100, CHK_MODEL, 24'h0, 1'b0},
    '{LAMP_SINGLE, 16'd65535, 16'd65535, OP_UPDATE, 32'd65791, 4'b1100, CHK_MODEL, 24'h0, 1'b0},
    // no lamp and the unused kind stay quiet
    '{LAMP_NONE, 16'd1000, 16'd200, OP_UPDATE, 32'd70000, 4'b1111, CHK_SILENT, 24'h0, 1'b0},
    '{LAMP_SPARE, 16'd1000, 16'd200, OP_UPDATE, 32'd71000, 4'b0101, CHK_SILENT, 24'h0, 1'b0},
    // back to color; the state timer only restarts on activity
    '{LAMP_COLOR, 16'd1000, 16'd200, OP_UPDATE, 32'h80000000, 4'b1110, CHK_MODEL, 24'h0, 1'b0},
    '{LAMP_COLOR, 16'd1000, 16'd200, OP_ACTIVITY, 32'd0, 4'b0000, CHK_SILENT, 24'h0, 1'b0},
    '{LAMP_COLOR, 16'd1000, 16'd200, OP_UPDATE, 32'd0, 4'b0000, CHK_MODEL, 24'h0, 1'b0},
    '{LAMP_COLOR, 16'd1000, 16'd200, OP_UPDATE, 32'd251, 4'b0000, CHK_MODEL, 24'h0, 1'b0}
  };

  // dut ports
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = OP_UPDATE;
  logic [31:0] now_ms = '0;
  logic        host_linked = 1'b0;
  logic        controller_present = 1'b0;
  logic        simulated = 1'b0;
  logic        startup_expired = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        lamp_on;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_LAMP_KIND;
  logic [15:0] cfg_data = '0;

  // pacing, owned by the stimulus process
  pace_t pace = PACE_FULL;
  logic  hold_go = 1'b0;

  // local copy of the lamp registers, reset values
  logic [1:0]  cfg_kind = LAMP_COLOR;
  logic [15:0] cfg_slow = SLOW_BLINK_RESET;
  logic [15:0] cfg_fast = FAST_BLINK_RESET;

  // sequencer state as the model sees it
  mode_t       seq_mode = ST_BOOT;
  logic [31:0] hold_start_ms = '0;
  logic [31:0] activity_ms = '0;
  logic [31:0] beat_ms = '0;
  logic        beat_phase = 1'b0;
  rgb_t        shown_colour = '0;

  lamp_result_t pending_results [$];

  logic [31:0] ms_clock = '0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned settings_count = 0;
  int unsigned cycle_count = 0;

  status_lamp_color_sequencer dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .operation          (operation),
    .now_ms             (now_ms),
    .host_linked        (host_linked),
    .controller_present (controller_present),
    .simulated          (simulated),
    .startup_expired    (startup_expired),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .red                (red),
    .green              (green),
    .blue               (blue),
    .lamp_on            (lamp_on),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // heartbeat window per state
  function automatic logic [31:0] beat_window(input mode_t m);
    case (m)
      ST_ACTIVE:    return 32'd80;
      ST_ERROR:     return 32'd120;
      ST_BOOT:      return 32'd180;
      ST_WAIT_HOST: return 32'd260;
      ST_WAIT_CTRL: return 32'd350;
      ST_READY:     return 32'd500;
      default:      return 32'd300;   // host connected
    endcase
  endfunction

  // color per state and heartbeat phase, as 0xRRGGBB
  function automatic rgb_t state_colour(input mode_t m, input logic p);
    case ({m, p})
      {ST_BOOT, 1'b0}:      return 24'h001040;
      {ST_BOOT, 1'b1}:      return 24'h400040;
      {ST_WAIT_HOST, 1'b0}: return 24'h000010;
      {ST_WAIT_HOST, 1'b1}: return 24'h000040;
      {ST_HOST_UP, 1'b0}:   return 24'h001810;
      {ST_HOST_UP, 1'b1}:   return 24'h004020;
      {ST_WAIT_CTRL, 1'b0}: return 24'h100800;
      {ST_WAIT_CTRL, 1'b1}: return 24'h401800;
      {ST_READY, 1'b0}:     return 24'h002000;
      {ST_READY, 1'b1}:     return 24'h006000;
      {ST_ACTIVE, 1'b0}:    return 24'h001010;
      {ST_ACTIVE, 1'b1}:    return 24'h006040;
      {ST_ERROR, 1'b0}:     return 24'h100000;
      {ST_ERROR, 1'b1}:     return 24'h780000;
      default:              return '0;
    endcase
  endfunction

  // runs one accepted item through the state rule and heartbeat
  // returns 1 when the item produces a result
  function automatic bit advance_sequencer(input lamp_item_t it, output lamp_result_t res);
    logic        driven;
    logic [31:0] since_activity;
    logic [31:0] since_hold;
    logic [31:0] since_beat;
    logic [31:0] period;
    rgb_t        c;
    driven = it.ctrl | it.sim;
    res = '0;
    if (it.op == OP_ACTIVITY) begin
      activity_ms = it.stamp;
      hold_start_ms = it.stamp;
      seq_mode = ST_ACTIVE;
      return 1'b0;
    end
    since_activity = it.stamp - activity_ms;
    since_hold = it.stamp - hold_start_ms;
    since_beat = it.stamp - beat_ms;

    if (it.expired) begin
      seq_mode = ST_ERROR;
    end else if (seq_mode == ST_ACTIVE) begin
      // activity lingers, then falls back by link status
      if (since_activity > ACTIVE_LINGER_MS) begin
        if (it.host && driven) seq_mode = ST_READY;
        else if (it.host) seq_mode = ST_HOST_UP;
        else seq_mode = ST_WAIT_HOST;
      end
    end else if (!it.host && since_hold < BOOT_GRACE_MS) begin
      seq_mode = ST_BOOT;
    end else if (!it.host) begin
      seq_mode = ST_WAIT_HOST;
    end else if (!driven) begin
      seq_mode = ST_WAIT_CTRL;
    end else begin
      seq_mode = ST_READY;
    end

    if (cfg_kind == LAMP_SINGLE) begin
      period = {16'd0, driven ? cfg_slow : cfg_fast};
      if (since_beat < period) return 1'b0;
      beat_ms = it.stamp;
      beat_phase = ~beat_phase;
      res.lamp = beat_phase;
      return 1'b1;
    end
    if (cfg_kind != LAMP_COLOR) return 1'b0;

    if (since_beat >= beat_window(seq_mode)) begin
      beat_ms = it.stamp;
      beat_phase = ~beat_phase;
    end
    c = state_colour(seq_mode, beat_phase);
    // only a change of color is sent
    if (c == shown_colour) return 1'b0;
    shown_colour = c;
    res.color = c;
    res.lamp = beat_phase;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // drop valid, then wait until every expected result has been taken
  // and then a settling wait for items that made none
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // only called with the block idle
  task automatic program_lamp(input logic [1:0] kind, input logic [15:0] slow,
                              input logic [15:0] fast);
    write_reg(REG_LAMP_KIND, {14'd0, kind});
    write_reg(REG_SLOW_BLINK, slow);
    write_reg(REG_FAST_BLINK, fast);
    cfg_we <= 1'b0;
    cfg_kind = kind;
    cfg_slow = slow;
    cfg_fast = fast;
    settings_count++;
  endtask

  function automatic bit sender_idles();
    case (pace)
      PACE_SEND_GAPS: return $urandom_range(0, 99) < 47;
      PACE_BOTH:      return $urandom_range(0, 99) < 26;
      default:        return 1'b0;
    endcase
  endfunction

  // offer one item, wait for the transfer, then predict its result
  task automatic offer_item(input lamp_item_t it, input check_t chk, input lamp_result_t given);
    lamp_result_t want;
    bit           makes;
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= it.op;
    now_ms <= it.stamp;
    host_linked <= it.host;
    controller_present <= it.ctrl;
    simulated <= it.sim;
    startup_expired <= it.expired;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;

    makes = advance_sequencer(it, want);
    case (chk)
      CHK_SILENT: begin
        if (makes) report_mismatch($sformatf("model gives a result at %0d ms", it.stamp));
      end
      CHK_RESULT: begin
        // the table value stands; the model has to agree with it
        if (!makes || want != given)
          report_mismatch($sformatf("model disagrees with table at %0d ms", it.stamp));
        makes = 1'b1;
        want = given;
      end
      default: ;
    endcase
    if (makes) pending_results.push_back(want);
  endtask

  // time mostly creeps forward, with jumps, repeats and trips across the wrap
  function automatic lamp_item_t random_item();
    lamp_item_t it;
    case ($urandom_range(0, 19))
      0:       ms_clock = $urandom();
      1:       ms_clock = 32'hFFFFFFFF - $urandom_range(0, 600);
      2:       ms_clock = ms_clock;   // same stamp again
      3:       ms_clock = ms_clock + $urandom_range(1000, 70000);
      default: ms_clock = ms_clock + $urandom_range(1, 400);
    endcase
    it.op = ($urandom_range(0, 99) < 8) ? OP_ACTIVITY : OP_UPDATE;
    it.stamp = ms_clock;
    it.host = $urandom_range(0, 99) < 70;
    it.ctrl = $urandom_range(0, 99) < 50;
    it.sim = $urandom_range(0, 99) < 30;
    it.expired = $urandom_range(0, 99) < 5;
    return it;
  endfunction

  task automatic random_phase(input logic [1:0] kind, input logic [15:0] slow,
                              input logic [15:0] fast, input pace_t mode,
                              input int unsigned count, input bit long_hold);
    settle();
    program_lamp(kind, slow, fast);
    pace <= mode;
    // the receiver holds off for a long stretch while items keep coming
    if (long_hold) hold_go <= 1'b1;
    repeat (count) offer_item(random_item(), CHK_MODEL, '0);
  endtask

  // receiver side: random stalls, plus one long hold-off on request
  int unsigned hold_left = 0;
  bit          hold_taken = 1'b0;

  always @(posedge clk) begin
    if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (pace)
        PACE_RECV_STALLS: out_ready <= $urandom_range(0, 99) >= 47;
        PACE_BOTH:        out_ready <= $urandom_range(0, 99) >= 26;
        default:          out_ready <= 1'b1;
      endcase
    end
  end

  // result checker: every output transfer against the oldest prediction
  always @(posedge clk) begin : result_check
    lamp_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = pending_results.pop_front();
        check_field("red", red, want.color.red);
        check_field("green", green, want.color.green);
        check_field("blue", blue, want.color.blue);
        check_field("lamp_on", {7'd0, lamp_on}, {7'd0, want.lamp});
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    directed_row_t row;
    lamp_item_t    it;
    lamp_result_t  given;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table, reprogrammed whenever a row asks for other settings
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_table[i];
      if (row.kind != cfg_kind || row.slow != cfg_slow || row.fast != cfg_fast) begin
        settle();
        program_lamp(row.kind, row.slow, row.fast);
      end
      it.op = row.op;
      it.stamp = row.stamp;
      {it.host, it.ctrl, it.sim, it.expired} = row.flags;
      given.color = row.colour;
      given.lamp = row.lamp;
      offer_item(it, row.check, given);
    end
    ms_clock = 32'd251;

    // random phases over lamp kinds, period extremes and pacing
    random_phase(LAMP_COLOR,  16'd1000,  16'd200,   PACE_FULL,        300, 1'b0);
    random_phase(LAMP_SINGLE, 16'd1000,  16'd200,   PACE_SEND_GAPS,   220, 1'b0);
    random_phase(LAMP_COLOR,  16'd65535, 16'd1,     PACE_RECV_STALLS, 260, 1'b1);
    random_phase(LAMP_SINGLE, 16'd1,     16'd65535, PACE_BOTH,        220, 1'b0);
    random_phase(LAMP_NONE,   16'd300,   16'd300,   PACE_BOTH,         50, 1'b0);
    random_phase(LAMP_SPARE,  16'd7,     16'd9,     PACE_FULL,         50, 1'b0);
    random_phase(LAMP_SINGLE, 16'd0,     16'd0,     PACE_RECV_STALLS, 120, 1'b0);
    random_phase(LAMP_COLOR,  16'd500,   16'd700,   PACE_BOTH,        200, 1'b0);
    settle();

    $display("run covered %0d input transfers and %0d result transfers", items_sent,
             results_seen);
    $display("over %0d lamp settings, all pacing modes and one long output hold-off",
             settings_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== status_lamp_color_sequencer.f =====
rtl/slcs_pkg.sv
rtl/status_lamp_color_sequencer.sv
tb/status_lamp_color_sequencer_tb.sv
